/* sv/mrlr_pkg.sv */
// ----------------------------------------------------------------------------
// mrlr_pkg: shared definitions for the Modbus RTU lux read transaction
// Operation and status codes, protocol constants, word structs and the
// byte-wide CRC-16 update used on both the request and the reply path.
// ----------------------------------------------------------------------------
package mrlr_pkg;

	// Input operation codes.
	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_BYTE    = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	// Result kinds.
	localparam logic KIND_TX   = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// Finish status codes.
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_TIMEOUT    = 2'd1;
	localparam logic [1:0] ST_BAD_HEADER = 2'd2;
	localparam logic [1:0] ST_CRC_BAD    = 2'd3;

	// Register select, taken from paddr bit 2 (registers lie 4 bytes apart).
	localparam int unsigned PADDR_W = 3;
	localparam logic REG_DEVICE_ADDRESS   = 1'b0;
	localparam logic REG_REGISTER_ADDRESS = 1'b1;

	// Register reset values.
	localparam logic [7:0]  DEVICE_ADDRESS_RST   = 8'h01;
	localparam logic [15:0] REGISTER_ADDRESS_RST = 16'h0007;

	// Protocol constants.
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  FUNC_READ   = 8'h03;
	localparam logic [7:0]  REPLY_COUNT = 8'h04;
	localparam logic [15:0] REG_COUNT   = 16'h0002;

	// Request byte currently offered by the transmit sequencer.
	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
	} tx_info_t;

	// Finish word offered by the reply checker for the item in the input stage.
	typedef struct packed {
		logic        emit;
		logic [1:0]  status;
		logic [31:0] lux_value;
	} rx_res_t;

	// One reflected CRC-16 byte update, eight bit steps.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* sv/mrlr_cmd_if.sv */
// ----------------------------------------------------------------------------
// mrlr_cmd_if: input channel
// Carries one operation word (op, rx_byte) with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrlr_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink (input valid, input op, input rx_byte, output ready);
endinterface

/* sv/mrlr_res_if.sv */
// ----------------------------------------------------------------------------
// mrlr_res_if: result channel
// Carries one result word (request byte or finished reading) with valid/ready.
// ----------------------------------------------------------------------------
interface mrlr_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  tx_byte;
	logic [31:0] lux_value;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, output kind, output tx_byte, output lux_value,
		output status, output last, input ready);
	modport sink (input valid, input kind, input tx_byte, input lux_value,
		input status, input last, output ready);
endinterface

/* sv/mrlr_tx.sv */
// ----------------------------------------------------------------------------
// mrlr_tx: request sequencer
// Steps through the eight request bytes, one per advance, folding each
// header byte into a running CRC so that the CRC bytes are ready at the end.
// ----------------------------------------------------------------------------
module mrlr_tx (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic [7:0]               device_address,
	input  logic [15:0]              register_address,
	output mrlr_pkg::tx_info_t       info
);

	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic [7:0]  cur_byte;

	always_comb begin
		unique case (idx_q)
			3'd0: cur_byte = device_address;
			3'd1: cur_byte = mrlr_pkg::FUNC_READ;
			3'd2: cur_byte = register_address[15:8];
			3'd3: cur_byte = register_address[7:0];
			3'd4: cur_byte = mrlr_pkg::REG_COUNT[15:8];
			3'd5: cur_byte = mrlr_pkg::REG_COUNT[7:0];
			3'd6: cur_byte = crc_q[7:0];
			default: cur_byte = crc_q[15:8];
		endcase
	end

	assign info.tx_byte = cur_byte;
	assign info.last    = (idx_q == 3'd7);

	// The index wraps to zero after the high CRC byte, ready for the next request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
			crc_q <= mrlr_pkg::CRC_INIT;
		end else if (advance) begin
			idx_q <= idx_q + 3'd1;
			if (idx_q == 3'd7) begin
				crc_q <= mrlr_pkg::CRC_INIT;
			end else if (idx_q < 3'd6) begin
				crc_q <= mrlr_pkg::crc_byte(crc_q, cur_byte);
			end
		end
	end

endmodule

/* sv/mrlr_rx.sv */
// ----------------------------------------------------------------------------
// mrlr_rx: reply checker
// Tracks the wait for the nine-byte reply, checks the header, collects the
// data bytes and the CRC, and offers the finish word on the last byte or
// on a timeout.
// ----------------------------------------------------------------------------
module mrlr_rx (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [1:0]           op,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           device_address,
	output mrlr_pkg::rx_res_t    res
);

	logic        waiting_q;
	logic [3:0]  count_q;
	logic [15:0] crc_q;
	logic        hdr_good_q;
	logic [31:0] value_q;
	logic [7:0]  crc_lo_q;

	logic is_byte;
	logic is_timeout;
	logic finish;

	assign is_byte    = (op == mrlr_pkg::OP_BYTE) && waiting_q;
	assign is_timeout = (op == mrlr_pkg::OP_TIMEOUT) && waiting_q;
	assign finish     = is_byte && (count_q == 4'd8);

	always_comb begin
		res.emit      = is_timeout || finish;
		res.status    = mrlr_pkg::ST_OK;
		res.lux_value = 32'd0;
		if (is_timeout) begin
			res.status = mrlr_pkg::ST_TIMEOUT;
		end else if (!hdr_good_q) begin
			res.status = mrlr_pkg::ST_BAD_HEADER;
		end else if (crc_lo_q != crc_q[7:0] || rx_byte != crc_q[15:8]) begin
			res.status = mrlr_pkg::ST_CRC_BAD;
		end else begin
			res.lux_value = value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q  <= 1'b0;
			count_q    <= 4'd0;
			crc_q      <= mrlr_pkg::CRC_INIT;
			hdr_good_q <= 1'b1;
			value_q    <= 32'd0;
			crc_lo_q   <= 8'd0;
		end else if (step) begin
			if (op == mrlr_pkg::OP_START || is_timeout || finish) begin
				// A start rearms the wait; a timeout or the last byte ends it.
				waiting_q  <= (op == mrlr_pkg::OP_START);
				count_q    <= 4'd0;
				crc_q      <= mrlr_pkg::CRC_INIT;
				hdr_good_q <= 1'b1;
				value_q    <= 32'd0;
				crc_lo_q   <= 8'd0;
			end else if (is_byte) begin
				unique case (count_q)
					4'd0: if (rx_byte != device_address) hdr_good_q <= 1'b0;
					4'd1: if (rx_byte != mrlr_pkg::FUNC_READ) hdr_good_q <= 1'b0;
					4'd2: if (rx_byte != mrlr_pkg::REPLY_COUNT) hdr_good_q <= 1'b0;
					4'd3, 4'd4, 4'd5, 4'd6: value_q <= {value_q[23:0], rx_byte};
					4'd7: crc_lo_q <= rx_byte;
					default: ;
				endcase
				if (count_q < 4'd7) begin
					crc_q <= mrlr_pkg::crc_byte(crc_q, rx_byte);
				end
				count_q <= count_q + 4'd1;
			end
		end
	end

endmodule

/* sv/modbus_rtu_lux_read_transaction.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_lux_read_transaction: Modbus RTU read of two holding registers
// Input stage, request sequencer, reply checker and one result register.
// ----------------------------------------------------------------------------
// A start word makes the block send the eight-byte read request (slave address,
// function 3, register address high then low, count 2, CRC-16 low then high),
// one result word per cycle while the result register is free, the eighth marked
// last; the start holds the input stage until its last byte is loaded. A byte or
// timeout word giving no result retires at once, so such words are accepted
// every cycle while a finished result waits in the result register; finishing
// ones wait until it is free. Received bytes feed a byte-wide CRC as they come
// in; the ninth reply byte gives one finish word carrying the big-endian reading
// and a status (ok, timeout, bad header, CRC mismatch; a bad header wins over a
// bad CRC). Bytes and timeouts while no reply is awaited, and operation code 3,
// give no result. Registers: device_address at byte address 0, register_address
// at byte address 4; write them only while the block is idle.
// ----------------------------------------------------------------------------
module modbus_rtu_lux_read_transaction (
	input  logic                                clk,
	input  logic                                arst_n,
	mrlr_cmd_if.sink                            cmd,
	mrlr_res_if.source                          res,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mrlr_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	// Configuration registers.
	logic [7:0]  device_address_q;
	logic [15:0] register_address_q;

	// Input stage.
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [7:0] rx_byte_s1;

	// Result register.
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  tx_byte_q;
	logic [31:0] lux_value_q;
	logic [1:0]  status_q;
	logic        last_q;

	mrlr_pkg::tx_info_t tx_info;
	mrlr_pkg::rx_res_t  rx_res;

	logic out_free;
	logic is_start;
	logic needs_out;
	logic load_out;
	logic s1_done;
	logic cfg_write;

	// ---------------------------------------------------------------- APB port
	// Zero-wait-state port; paddr bit 2 selects the register, the low bits are
	// the byte offset within it.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			mrlr_pkg::REG_DEVICE_ADDRESS:   prdata = {24'd0, device_address_q};
			mrlr_pkg::REG_REGISTER_ADDRESS: prdata = {16'd0, register_address_q};
			default:                        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q   <= mrlr_pkg::DEVICE_ADDRESS_RST;
			register_address_q <= mrlr_pkg::REGISTER_ADDRESS_RST;
		end else if (cfg_write) begin
			if (paddr[2] == mrlr_pkg::REG_DEVICE_ADDRESS) begin
				device_address_q <= pwdata[7:0];
			end else begin
				register_address_q <= pwdata[15:0];
			end
		end
	end

	// ---------------------------------------------------------- flow control
	// The result register can take a word when it is empty or being drained.
	assign out_free  = !out_valid_q || res.ready;
	assign is_start  = valid_s1 && (op_s1 == mrlr_pkg::OP_START);
	assign needs_out = is_start || rx_res.emit;
	assign load_out  = valid_s1 && needs_out && out_free;

	// The input word retires once its last result word is loaded, or at once
	// when it produces nothing.
	assign s1_done   = valid_s1 && (!needs_out || (out_free && (!is_start || tx_info.last)));
	assign cmd.ready = !valid_s1 || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1      <= cmd.op;
			rx_byte_s1 <= cmd.rx_byte;
		end
	end

	// ------------------------------------------------------- request and reply
	mrlr_tx u_tx (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (is_start && load_out),
		.device_address   (device_address_q),
		.register_address (register_address_q),
		.info             (tx_info)
	);

	mrlr_rx u_rx (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (s1_done),
		.op             (op_s1),
		.rx_byte        (rx_byte_s1),
		.device_address (device_address_q),
		.res            (rx_res)
	);

	// --------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// A request byte carries no reading and an ok status; a finish word is
	// always the only and last word of its input word.
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (is_start) begin
				kind_q      <= mrlr_pkg::KIND_TX;
				tx_byte_q   <= tx_info.tx_byte;
				lux_value_q <= 32'd0;
				status_q    <= mrlr_pkg::ST_OK;
				last_q      <= tx_info.last;
			end else begin
				kind_q      <= mrlr_pkg::KIND_DONE;
				tx_byte_q   <= 8'd0;
				lux_value_q <= rx_res.lux_value;
				status_q    <= rx_res.status;
				last_q      <= 1'b1;
			end
		end
	end

	assign res.valid     = out_valid_q;
	assign res.kind      = kind_q;
	assign res.tx_byte   = tx_byte_q;
	assign res.lux_value = lux_value_q;
	assign res.status    = status_q;
	assign res.last      = last_q;

	// -------------------------------------------------------------- assertions
	// A finish word always closes its input word.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == mrlr_pkg::KIND_DONE |-> res.last)
		else $error("finish word without last");

	// A reading is only ever reported with an ok finish.
	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.lux_value != 32'd0 |->
		res.kind == mrlr_pkg::KIND_DONE && res.status == mrlr_pkg::ST_OK)
		else $error("reading reported without ok status");

	// A start leaves the input stage only with its high CRC byte.
	a_start_retires_last: assert property (@(posedge clk) disable iff (!arst_n)
		s1_done && is_start |-> tx_info.last && load_out)
		else $error("start retired before the whole request was sent");

	// A request byte loaded with last set is followed by a fresh sequence.
	a_seq_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && is_start && tx_info.last |=> tx_info.tx_byte == device_address_q)
		else $error("request sequencer did not wrap to the address byte");

endmodule
